// ----- hw/rtl/hysteresis_thermostat_with_buttons_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the thermostat block
// Clocked wrappers around concurrent assertions, with and without a reset gate.
// ---------------------------------------------------------------------------
`ifndef HYSTERESIS_THERMOSTAT_WITH_BUTTONS_ASSERT_SVH
`define HYSTERESIS_THERMOSTAT_WITH_BUTTONS_ASSERT_SVH

// Assertion sampled on clk_i, held off while rst_ni is low
`define HTWB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same, checked also while reset is asserted
`define HTWB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- hw/rtl/htwb_pkg.sv -----
// ---------------------------------------------------------------------------
// htwb_pkg
// Shared types, register map and helpers for the thermostat block.
// ---------------------------------------------------------------------------
package htwb_pkg;

  // Configuration port geometry
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegMargin      = 3'd0;
  localparam logic [CfgIdxW-1:0] RegStepSize    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegReadPeriod  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegShowTicks   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRepeatTicks = 3'd4;

  // Register reset values
  localparam logic [7:0]  MarginRst      = 8'd10;
  localparam logic [5:0]  StepSizeRst    = 6'd5;
  localparam logic [15:0] ReadPeriodRst  = 16'd200;
  localparam logic [15:0] ShowTicksRst   = 16'd300;
  localparam logic [15:0] RepeatTicksRst = 16'd25;

  // Target limits and reset, tenths of a degree
  localparam logic signed [11:0] TargetRst = 12'sd240;
  localparam logic signed [13:0] TargetMin = -14'sd500;
  localparam logic signed [13:0] TargetMax = 14'sd1500;

  typedef enum logic [1:0] {
    PWR_UNKNOWN = 2'd0,
    PWR_ON      = 2'd1,
    PWR_OFF     = 2'd2
  } pwr_e;

  typedef enum logic [1:0] {
    SEND_NONE = 2'd0,
    SEND_ON   = 2'd1,
    SEND_OFF  = 2'd2
  } send_e;

  typedef struct packed {
    logic [7:0]  margin;
    logic [5:0]  step_size;
    logic [15:0] read_period;
    logic [15:0] show_ticks;
    logic [15:0] repeat_ticks;
  } cfg_t;

  typedef struct packed {
    logic              warm_pressed;
    logic              cold_pressed;
    logic              reading_ok;
    logic signed [11:0] heat_index;
  } in_t;

  typedef struct packed {
    logic              show_target;
    logic signed [11:0] target_value;
    logic signed [11:0] shown_reading;
    logic              reading_seen;
    send_e             send_code;
    pwr_e              power_state;
  } out_t;

  // Saturate a widened target back into the legal range
  function automatic logic signed [11:0] clamp_target(input logic signed [13:0] v);
    logic signed [13:0] r;
    r = v;
    if (v < TargetMin) r = TargetMin;
    if (v > TargetMax) r = TargetMax;
    return r[11:0];
  endfunction

endpackage

// ----- hw/rtl/htwb_cfg.sv -----
// ---------------------------------------------------------------------------
// htwb_cfg
// Configuration register file: decodes writes and masks data to width.
// ---------------------------------------------------------------------------
module htwb_cfg
  import htwb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Write decode; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMargin:      cfg_d.margin       = cfg_wdata_i[7:0];
        RegStepSize:    cfg_d.step_size    = cfg_wdata_i[5:0];
        RegReadPeriod:  cfg_d.read_period  = cfg_wdata_i;
        RegShowTicks:   cfg_d.show_ticks   = cfg_wdata_i;
        RegRepeatTicks: cfg_d.repeat_ticks = cfg_wdata_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.margin       <= MarginRst;
      cfg_q.step_size    <= StepSizeRst;
      cfg_q.read_period  <= ReadPeriodRst;
      cfg_q.show_ticks   <= ShowTicksRst;
      cfg_q.repeat_ticks <= RepeatTicksRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/hysteresis_thermostat_with_buttons.sv -----
// ---------------------------------------------------------------------------
// hysteresis_thermostat_with_buttons
// Bang-bang thermostat with hysteresis band and two target-step buttons.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one tick per beat:
//   two button levels, a sensor-ok flag and a signed heat index. Output channel
//   (out_valid_o/out_ready_i/out_data_o) returns exactly one result beat per
//   input beat, in order.
//   Path: an accepted beat goes into the input register, then into the result
//   register together with the state update, and is presented at out_valid_o.
//   Throughput: one beat per cycle while out_ready_i stays high; all tick work is a single pass of adds,
//   compares and countdowns between the two registers.
//   Stall: when out_ready_i is low with a result presented, the result register holds; the input
//   register still takes one more beat, after which in_ready_o drops.
//   Reset: registers return to their documented values (margin 10, step 5,
//   period 200, show 300, repeat 25), target 24.0 degrees, power unknown,
//   counters zero, both stages empty. No clearing pass.
//   Config (cfg_we_i/cfg_idx_i/cfg_wdata_i) is written while no beat is in
//   flight; writes take effect at the next edge.
// ---------------------------------------------------------------------------
`include "hysteresis_thermostat_with_buttons_assert.svh"

module hysteresis_thermostat_with_buttons
  import htwb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_data_o
);

  cfg_t cfg;

  htwb_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // Pipeline handshake
  logic s1_valid_q, out_valid_q;
  in_t  s1_q;
  out_t out_q, out_d;
  logic s2_ready, s2_fire;

  assign s2_ready   = !out_valid_q || out_ready_i;
  assign s2_fire    = s1_valid_q && s2_ready;
  assign in_ready_o = !s1_valid_q || s2_ready;

  // Thermostat state
  logic signed [11:0] target_q, target_d;
  pwr_e               heater_q, heater_d;
  logic signed [11:0] last_rd_q, last_rd_d;
  logic               have_rd_q, have_rd_d;
  logic [15:0]        phase_q, phase_d;
  logic [15:0]        holdoff_q, holdoff_d;
  logic [15:0]        window_q, window_d;

  // Tick evaluation
  logic [15:0]        window_dec, holdoff_dec;
  logic               window_open, acc_warm, acc_cold;
  logic signed [13:0] step_s, margin_s, hi_s, t_tmp, lo_thr, hi_thr;
  logic signed [11:0] t_warm;
  send_e              send;

  always_comb begin
    window_dec  = (window_q != '0) ? window_q - 16'd1 : window_q;
    holdoff_dec = (holdoff_q != '0) ? holdoff_q - 16'd1 : holdoff_q;
    window_open = (window_dec != '0);
    acc_warm    = s1_q.warm_pressed && (holdoff_dec == '0);
    acc_cold    = s1_q.cold_pressed && (holdoff_dec == '0);
    step_s      = $signed({8'd0, cfg.step_size});
    margin_s    = $signed({6'd0, cfg.margin});
    hi_s        = 14'(s1_q.heat_index);

    // Button steps: warm first, then cold, each saturated
    t_tmp  = 14'(target_q) + step_s;
    t_warm = (acc_warm && window_open) ? clamp_target(t_tmp) : target_q;
    t_tmp  = 14'(t_warm) - step_s;
    target_d = (acc_cold && window_open) ? clamp_target(t_tmp) : t_warm;

    // Holdoff and show window
    holdoff_d = holdoff_dec;
    window_d  = window_dec;
    if (!s1_q.warm_pressed && !s1_q.cold_pressed) holdoff_d = '0;
    if (acc_warm || acc_cold) begin
      holdoff_d = cfg.repeat_ticks;
      window_d  = cfg.show_ticks;
    end

    // Sensor evaluation every read_period ticks
    phase_d   = phase_q + 16'd1;
    last_rd_d = last_rd_q;
    have_rd_d = have_rd_q;
    heater_d  = heater_q;
    send      = SEND_NONE;
    lo_thr    = 14'(target_d) - margin_s;
    hi_thr    = 14'(target_d) + margin_s;
    if (phase_d >= cfg.read_period) begin
      phase_d = '0;
      if (s1_q.reading_ok) begin
        last_rd_d = s1_q.heat_index;
        have_rd_d = 1'b1;
        if (hi_s < lo_thr && heater_d != PWR_ON) begin
          send     = SEND_ON;
          heater_d = PWR_ON;
        end
        if (hi_s > hi_thr && heater_d != PWR_OFF) begin
          send     = SEND_OFF;
          heater_d = PWR_OFF;
        end
      end
    end

    out_d.show_target   = window_open;
    out_d.target_value  = target_d;
    out_d.shown_reading = last_rd_d;
    out_d.reading_seen  = have_rd_d;
    out_d.send_code     = send;
    out_d.power_state   = heater_d;
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      target_q    <= TargetRst;
      heater_q    <= PWR_UNKNOWN;
      last_rd_q   <= '0;
      have_rd_q   <= 1'b0;
      phase_q     <= '0;
      holdoff_q   <= '0;
      window_q    <= '0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (s2_ready)   out_valid_q <= s1_valid_q;
      if (s2_fire) begin
        target_q  <= target_d;
        heater_q  <= heater_d;
        last_rd_q <= last_rd_d;
        have_rd_q <= have_rd_d;
        phase_q   <= phase_d;
        holdoff_q <= holdoff_d;
        window_q  <= window_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) s1_q <= in_data_i;
    if (s2_fire) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  `HTWB_ASSERT(a_send_needs_reading,
    (out_valid_q && out_q.send_code != SEND_NONE) |-> out_q.reading_seen,
    "heater command without any stored reading")
  `HTWB_ASSERT(a_send_matches_power,
    (out_valid_q && out_q.send_code == SEND_ON) |-> (out_q.power_state == PWR_ON),
    "heater-on command but power state not on")
  `HTWB_ASSERT(a_target_range,
    (target_q >= 12'sh E0C) && (target_q <= 12'sd1500),
    "target left the legal range")
  `HTWB_ASSERT(a_stall_only_when_full,
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i),
    "input stalled while the pipeline has room")

endmodule

// ----- tb/hysteresis_thermostat_with_buttons_test.sv -----
// ----------------------------------------------------------------------------
// Thermostat block testbench
// Drives tick beats through the valid/ready input channel and checks every
// result beat against a cycle-free model of the thermostat kept in this file.
// Directed tests cover button windows, target limits, heater commands and
// corner register values; a random phase mixes button sequences, readings
// near the hysteresis band and random register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hysteresis_thermostat_with_buttons_test;
  import htwb_pkg::*;

  // DUT ports, all driven to known values from time zero
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_t                 in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_t                out_data_o;

  hysteresis_thermostat_with_buttons dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // Model copy of the registers
  int cfg_margin = int'(MarginRst);
  int cfg_step   = int'(StepSizeRst);
  int cfg_period = int'(ReadPeriodRst);
  int cfg_show   = int'(ShowTicksRst);
  int cfg_repeat = int'(RepeatTicksRst);

  // Model copy of the thermostat state
  int   setpoint     = int'(TargetRst);
  pwr_e heater       = PWR_UNKNOWN;
  int   last_reading = 0;
  bit   have_reading = 1'b0;
  int   phase        = 0;
  int   holdoff      = 0;
  int   window       = 0;

  out_t due_readouts[$];
  int   mismatches   = 0;
  int   burst_left   = 0;
  bit   sender_gaps  = 1'b1;

  // Keep the target inside its legal span
  function automatic int limit_setpoint(input int v);
    if (v < -500) return -500;
    if (v > 1500) return 1500;
    return v;
  endfunction

  // One tick of the thermostat: returns the readout it produces
  function automatic out_t step_thermostat(input in_t t);
    out_t  r;
    bit    open;
    bit    took;
    send_e send;
    int    hi;
    hi   = int'($signed(t.heat_index));
    took = 1'b0;
    send = SEND_NONE;
    if (window != 0) window--;
    if (holdoff != 0) holdoff--;
    open = (window != 0);
    // warm steps first, then cold
    if (t.warm_pressed && holdoff == 0) begin
      if (open) setpoint = limit_setpoint(setpoint + cfg_step);
      took = 1'b1;
    end
    if (t.cold_pressed && holdoff == 0) begin
      if (open) setpoint = limit_setpoint(setpoint - cfg_step);
      took = 1'b1;
    end
    if (!t.warm_pressed && !t.cold_pressed) holdoff = 0;
    if (took) begin
      holdoff = cfg_repeat;
      window  = cfg_show;
    end
    // sensor evaluation at the end of each period
    phase = (phase + 1) & 'hFFFF;
    if (phase >= cfg_period) begin
      phase = 0;
      if (t.reading_ok) begin
        last_reading = hi;
        have_reading = 1'b1;
        if (hi < setpoint - cfg_margin && heater != PWR_ON) begin
          send   = SEND_ON;
          heater = PWR_ON;
        end
        if (hi > setpoint + cfg_margin && heater != PWR_OFF) begin
          send   = SEND_OFF;
          heater = PWR_OFF;
        end
      end
    end
    r.show_target   = open;
    r.target_value  = setpoint[11:0];
    r.shown_reading = last_reading[11:0];
    r.reading_seen  = have_reading;
    r.send_code     = send;
    r.power_state   = heater;
    return r;
  endfunction

  // Predict at every accepted tick beat
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) due_readouts.push_back(step_thermostat(in_data_i));
  end

  // Compare every accepted result beat with the oldest prediction
  always @(posedge clk_i) begin : check_results
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_readouts.size() == 0) begin
        $error("result beat with no tick outstanding");
        mismatches++;
      end else begin
        want = due_readouts.pop_front();
        if (out_data_o.show_target !== want.show_target) begin
          $error("show_target expected %0d got %0d", want.show_target, out_data_o.show_target);
          mismatches++;
        end
        if (out_data_o.target_value !== want.target_value) begin
          $error("target_value expected %0d got %0d", want.target_value,
                 out_data_o.target_value);
          mismatches++;
        end
        if (out_data_o.shown_reading !== want.shown_reading) begin
          $error("shown_reading expected %0d got %0d", want.shown_reading,
                 out_data_o.shown_reading);
          mismatches++;
        end
        if (out_data_o.reading_seen !== want.reading_seen) begin
          $error("reading_seen expected %0d got %0d", want.reading_seen,
                 out_data_o.reading_seen);
          mismatches++;
        end
        if (out_data_o.send_code !== want.send_code) begin
          $error("send_code expected %0d got %0d", want.send_code, out_data_o.send_code);
          mismatches++;
        end
        if (out_data_o.power_state !== want.power_state) begin
          $error("power_state expected %0d got %0d", want.power_state, out_data_o.power_state);
          mismatches++;
        end
      end
    end
  end

  // Receiver: steady, random, or long on/off stretches, in a mode that is picked anew at random
  int rx_cycle = 0;
  int rx_mode  = 0;
  int rx_hold  = 0;
  bit rx_level = 1'b1;
  always @(posedge clk_i) begin
    if (rx_cycle % 256 == 0) rx_mode = $urandom_range(0, 2);
    rx_cycle++;
    case (rx_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      default: begin
        if (rx_hold == 0) begin
          rx_level = !rx_level;
          rx_hold  = $urandom_range(1, 8);
        end
        rx_hold--;
        out_ready_i <= rx_level;
      end
    endcase
  end

  function automatic in_t make_tick(input bit warm, input bit cold, input bit ok, input int hi);
    in_t t;
    t.warm_pressed = warm;
    t.cold_pressed = cold;
    t.reading_ok   = ok;
    t.heat_index   = hi[11:0];
    return t;
  endfunction

  // Send one tick beat; the sender idles between bursts of random length
  task automatic send_tick(input in_t t);
    bit rdy;
    if (burst_left == 0) begin
      if (sender_gaps) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    // ready only moves at rising edges, so sample it mid-cycle
    do begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end while (!rdy);
  endtask

  // Hold off the sender until every predicted readout has come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (due_readouts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegMargin:      cfg_margin = int'(val[7:0]);
      RegStepSize:    cfg_step   = int'(val[5:0]);
      RegReadPeriod:  cfg_period = int'(val);
      RegShowTicks:   cfg_show   = int'(val);
      RegRepeatTicks: cfg_repeat = int'(val);
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic apply_setting(input int m, input int s, input int p, input int sh, input int r);
    wait_idle();
    write_reg(RegMargin, CfgDataW'(m));
    write_reg(RegStepSize, CfgDataW'(s));
    write_reg(RegReadPeriod, CfgDataW'(p));
    write_reg(RegShowTicks, CfgDataW'(sh));
    write_reg(RegRepeatTicks, CfgDataW'(r));
  endtask

  // Reset values: first press only opens the window, holdoff, both buttons
  task automatic test_buttons_and_window();
    send_tick(make_tick(0, 0, 0, 0));
    send_tick(make_tick(0, 0, 1, 250));
    send_tick(make_tick(1, 0, 1, 250));
    send_tick(make_tick(0, 0, 1, 250));
    send_tick(make_tick(1, 0, 0, 250));
    send_tick(make_tick(1, 0, 0, 250));
    send_tick(make_tick(1, 0, 0, 250));
    send_tick(make_tick(0, 0, 0, 250));
    send_tick(make_tick(0, 1, 1, 250));
    send_tick(make_tick(0, 0, 1, 250));
    send_tick(make_tick(1, 1, 1, 250));
    send_tick(make_tick(1, 1, 1, 250));
    send_tick(make_tick(0, 0, 1, 250));
  endtask

  // Step masked to its width, held buttons repeat every tick, target saturates
  task automatic test_target_limits();
    wait_idle();
    write_reg(RegMargin, 16'd10);
    write_reg(RegStepSize, 16'hFFFF);
    write_reg(RegReadPeriod, 16'd1);
    write_reg(RegShowTicks, 16'hFFFF);
    write_reg(RegRepeatTicks, 16'd1);
    repeat (25) send_tick(make_tick(1, 0, 1'($urandom_range(0, 1)), $urandom_range(0, 1500)));
    send_tick(make_tick(0, 0, 1, 700));
    repeat (36) send_tick(make_tick(0, 1, 1'($urandom_range(0, 1)), $urandom_range(0, 1500)));
  endtask

  // Heater commands at both ends of the band, invalid readings, no resend
  task automatic test_heater_control();
    apply_setting(0, 5, 1, 1, 1);
    send_tick(make_tick(0, 0, 1, -2048));
    send_tick(make_tick(0, 0, 1, -2048));
    send_tick(make_tick(0, 0, 1, 2047));
    send_tick(make_tick(0, 0, 0, -2048));
    send_tick(make_tick(0, 0, 1, -500));
    send_tick(make_tick(0, 0, 1, -501));
    send_tick(make_tick(0, 0, 1, 1500));
    wait_idle();
    write_reg(RegMargin, 16'hFFFF);
    send_tick(make_tick(0, 0, 1, -756));
    send_tick(make_tick(0, 0, 1, -755));
    send_tick(make_tick(0, 0, 1, -245));
    send_tick(make_tick(0, 0, 1, -244));
    // invalid reading on an evaluation tick still restarts the period
    wait_idle();
    write_reg(RegReadPeriod, 16'd3);
    send_tick(make_tick(0, 0, 1, -2048));
    send_tick(make_tick(0, 0, 1, -2048));
    send_tick(make_tick(0, 0, 0, -2048));
    send_tick(make_tick(0, 0, 1, -2048));
    send_tick(make_tick(0, 0, 1, -2048));
    send_tick(make_tick(0, 0, 1, -2048));
  endtask

  // Zero period, zero step, zero window, zero holdoff, unused register indexes
  task automatic test_zero_settings();
    apply_setting(255, 0, 0, 0, 0);
    send_tick(make_tick(1, 0, 1, 1000));
    send_tick(make_tick(1, 0, 1, -1000));
    send_tick(make_tick(1, 1, 1, 1000));
    send_tick(make_tick(0, 1, 0, 0));
    send_tick(make_tick(0, 0, 1, 300));
    wait_idle();
    write_reg(RegShowTicks, 16'd5);
    send_tick(make_tick(1, 0, 1, 240));
    send_tick(make_tick(1, 0, 1, 240));
    send_tick(make_tick(0, 1, 1, 240));
    send_tick(make_tick(0, 0, 1, 240));
    wait_idle();
    for (int k = 1; k <= 3; k++) write_reg(CfgIdxW'(RegRepeatTicks + k), 16'hFFFF);
    send_tick(make_tick(1, 0, 1, 2047));
    send_tick(make_tick(0, 0, 1, -2048));
  endtask

  // Every register at its largest encoding
  task automatic test_register_extremes();
    wait_idle();
    write_reg(RegMargin, 16'hFFFF);
    write_reg(RegStepSize, 16'hFFFF);
    write_reg(RegReadPeriod, 16'hFFFF);
    write_reg(RegShowTicks, 16'hFFFF);
    write_reg(RegRepeatTicks, 16'hFFFF);
    send_tick(make_tick(1, 0, 1, 100));
    send_tick(make_tick(1, 0, 1, 100));
    send_tick(make_tick(0, 0, 1, 100));
    send_tick(make_tick(1, 0, 1, 100));
    send_tick(make_tick(0, 0, 1, 100));
    send_tick(make_tick(0, 1, 1, 100));
  endtask

  // Random settings per phase; press/release sequences with some noise,
  // readings mostly near the hysteresis band
  task automatic test_random_traffic();
    int sent;
    int hold;
    int kind;
    int span;
    int hi;
    int m, s, p, sh, r;
    bit warm, cold;
    sent = 0;
    while (sent < 800) begin
      case ($urandom_range(0, 3))
        0: m = 0;
        1: m = 255;
        default: m = $urandom_range(0, 255);
      endcase
      case ($urandom_range(0, 5))
        0: s = 0;
        1: s = 1;
        2: s = 50;
        3: s = 63;
        default: s = $urandom_range(1, 50);
      endcase
      case ($urandom_range(0, 9))
        0: p = 0;
        1: p = $urandom_range(20, 80);
        default: p = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 9))
        0: sh = 0;
        1: sh = 65535;
        default: sh = $urandom_range(1, 30);
      endcase
      case ($urandom_range(0, 9))
        0: r = 0;
        1: r = 65535;
        default: r = $urandom_range(1, 8);
      endcase
      apply_setting(m, s, p, sh, r);
      sender_gaps = ($urandom_range(0, 3) != 0);
      hold = 0;
      warm = 1'b0;
      cold = 1'b0;
      repeat ($urandom_range(60, 120)) begin
        if ($urandom_range(0, 9) == 0) begin
          warm = 1'($urandom_range(0, 1));
          cold = 1'($urandom_range(0, 1));
          hold = 0;
        end else if (hold == 0) begin
          if (warm || cold) begin
            warm = 1'b0;
            cold = 1'b0;
            hold = $urandom_range(1, 5);
          end else begin
            kind = $urandom_range(0, 4);
            warm = (kind < 2) || (kind == 4);
            cold = (kind >= 2);
            hold = $urandom_range(1, 6);
          end
        end
        if (hold > 0) hold--;
        if ($urandom_range(0, 9) == 0) begin
          hi = int'($urandom_range(0, 4095)) - 2048;
        end else begin
          span = cfg_margin + 20;
          hi   = setpoint + int'($urandom_range(0, 2 * span)) - span;
          if (hi < -2048) hi = -2048;
          if (hi > 2047) hi = 2047;
        end
        send_tick(make_tick(warm, cold, $urandom_range(0, 7) != 0, hi));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_buttons_and_window();
    test_target_limits();
    test_heater_control();
    test_zero_settings();
    test_register_extremes();
    test_random_traffic();
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (due_readouts.size() != 0) begin
      $error("%0d readouts never arrived", due_readouts.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
